### src/kts_pkg.sv
// shared types and spelling tables for the kana to romaji stream unit
// no dependencies

package kts_pkg;

  localparam logic [15:0] CP_LONG_MARK = 16'h30FC;
  localparam logic [15:0] CP_SMALL_TSU = 16'h3063;
  localparam logic [15:0] KANA_BASE    = 16'h3040;
  localparam logic [15:0] KANA_END     = 16'h30A0;
  localparam logic [7:0]  NO_KANA      = 8'hFF;
  localparam logic [7:0]  OFF_N        = 8'h53;
  localparam logic [7:0]  OFF_JI       = 8'h18;
  localparam int          MAX_CHARS    = 7;

  typedef struct packed {
    logic [7:0] held_kana;
    logic       held_valid;
    logic       double_pending;
    logic       output_started;
    logic       error_seen;
  } kts_state_t;

  // up to three ascii chars, first char in byte len-1 of text (the highest used byte)
  typedef struct packed {
    logic [1:0]  len;
    logic [23:0] text;
  } kts_spell_t;

  typedef struct packed {
    logic [2:0]                n;
    logic [MAX_CHARS-1:0][6:0] ch;
    logic                      done;
    logic                      inv;
  } kts_burst_t;

  function automatic kts_spell_t kts_spell(input logic [7:0] off);
    kts_spell_t r;
    r.len = 2'd2;
    r.text = 24'h0;
    case (off)
      8'h01, 8'h02: begin r.len = 2'd1; r.text = "a"; end
      8'h03, 8'h04: begin r.len = 2'd1; r.text = "i"; end
      8'h05, 8'h06: begin r.len = 2'd1; r.text = "u"; end
      8'h07, 8'h08: begin r.len = 2'd1; r.text = "e"; end
      8'h09, 8'h0A: begin r.len = 2'd1; r.text = "o"; end
      8'h0B: r.text = "ka";  8'h0C: r.text = "ga";
      8'h0D: r.text = "ki";  8'h0E: r.text = "gi";
      8'h0F: r.text = "ku";  8'h10: r.text = "gu";
      8'h11: r.text = "ke";  8'h12: r.text = "ge";
      8'h13: r.text = "ko";  8'h14: r.text = "go";
      8'h15: r.text = "sa";  8'h16: r.text = "za";
      8'h17: begin r.len = 2'd3; r.text = "shi"; end
      8'h18: r.text = "ji";  8'h19: r.text = "su";
      8'h1A: r.text = "zu";  8'h1B: r.text = "se";
      8'h1C: r.text = "ze";  8'h1D: r.text = "so";
      8'h1E: r.text = "zo";  8'h1F: r.text = "ta";
      8'h20: r.text = "da";
      8'h21: begin r.len = 2'd3; r.text = "chi"; end
      8'h22: r.text = "di";
      8'h24: begin r.len = 2'd3; r.text = "tsu"; end
      8'h25: r.text = "du";  8'h26: r.text = "te";
      8'h27: r.text = "de";  8'h28: r.text = "to";
      8'h29: r.text = "do";  8'h2A: r.text = "na";
      8'h2B: r.text = "ni";  8'h2C: r.text = "nu";
      8'h2D: r.text = "ne";  8'h2E: r.text = "no";
      8'h2F: r.text = "ha";  8'h30: r.text = "ba";
      8'h31: r.text = "pa";  8'h32: r.text = "hi";
      8'h33: r.text = "bi";  8'h34: r.text = "pi";
      8'h35: r.text = "fu";  8'h36: r.text = "bu";
      8'h37: r.text = "pu";  8'h38: r.text = "he";
      8'h39: r.text = "be";  8'h3A: r.text = "pe";
      8'h3B: r.text = "ho";  8'h3C: r.text = "bo";
      8'h3D: r.text = "po";  8'h3E: r.text = "ma";
      8'h3F: r.text = "mi";  8'h40: r.text = "mu";
      8'h41: r.text = "me";  8'h42: r.text = "mo";
      8'h43, 8'h44: r.text = "ya";
      8'h45, 8'h46: r.text = "yu";
      8'h47, 8'h48: r.text = "yo";
      8'h49: r.text = "ra";  8'h4A: r.text = "ri";
      8'h4B: r.text = "ru";  8'h4C: r.text = "re";
      8'h4D: r.text = "ro";
      8'h4E, 8'h4F: r.text = "wa";
      8'h52: r.text = "wo";
      8'h53: begin r.len = 2'd1; r.text = "n"; end
      8'h54: r.text = "vu";
      default: r.len = 2'd0;
    endcase
    return r;
  endfunction

  // stem of contracted syllables, len 0 where the kana has none
  function automatic kts_spell_t kts_stem(input logic [7:0] off);
    kts_spell_t r;
    r.len = 2'd2;
    r.text = 24'h0;
    case (off)
      8'h0D: r.text = "ky";  8'h17: r.text = "sh";
      8'h21: r.text = "ch";  8'h2B: r.text = "ny";
      8'h32: r.text = "hy";  8'h3F: r.text = "my";
      8'h4A: r.text = "ry";  8'h0E: r.text = "gy";
      8'h18: begin r.len = 2'd1; r.text = "j"; end
      8'h22: r.text = "dy";  8'h33: r.text = "by";
      8'h34: r.text = "py";
      default: r.len = 2'd0;
    endcase
    return r;
  endfunction

  function automatic logic kts_is_small(input logic [7:0] off);
    return off == 8'h01 || off == 8'h03 || off == 8'h05 || off == 8'h07 ||
           off == 8'h09 || off == 8'h43 || off == 8'h45 || off == 8'h47 ||
           off == 8'h4E;
  endfunction

  function automatic logic [7:0] kts_first(input kts_spell_t s);
    logic [7:0] c;
    c = 8'h0;
    if (s.len != 2'd0) c = s.text[8*(int'(s.len)-1) +: 8];
    return c;
  endfunction

  function automatic logic kts_is_vowel(input logic [7:0] c);
    return c == "a" || c == "e" || c == "i" || c == "o" || c == "u";
  endfunction

endpackage

### src/kts_xlate.sv
// per-item translation: turns one code point and the held state into a burst
// of romaji chars, an optional end result and the next state; uses kts_pkg

module kts_xlate (
  input  logic [15:0]         code_point,
  input  logic                string_last,
  input  kts_pkg::kts_state_t st,
  output kts_pkg::kts_state_t st_nxt,
  output kts_pkg::kts_burst_t burst
);
  import kts_pkg::*;

  logic [7:0] x;
  kts_spell_t sp_x, sp_h, sm_h;
  logic [6:0] dvow;

  assign x    = (code_point >= KANA_BASE && code_point < KANA_END) ?
                8'(code_point - KANA_BASE) : NO_KANA;
  assign sp_x = kts_spell(x);
  assign sp_h = kts_spell(st.held_kana);
  assign sm_h = kts_stem(st.held_kana);

  // vowel that completes a contracted syllable, zero when the pair is none
  always_comb begin
    dvow = 7'h0;
    if (sm_h.len != 2'd0) begin
      if (x == 8'h43) dvow = 7'("a");
      else if (x == 8'h45) dvow = 7'("u");
      else if (x == 8'h47) dvow = 7'("o");
      else if (x == 8'h07 && st.held_kana == OFF_JI) dvow = 7'("e");
    end
  end

  // walk the spelling rules in order, appending chars to the burst
  always_comb begin
    kts_state_t s;
    logic       consumed;
    logic [2:0] n;
    logic [7:0] c0;
    s = st;
    consumed = 1'b0;
    n = 3'd0;
    burst.ch = '0;
    c0 = kts_first(sp_x);
    if (!s.error_seen) begin
      if (s.held_valid) begin
        s.held_valid = 1'b0;
        if (dvow != 7'h0) begin
          for (int i = 0; i < 2; i++) begin
            if (i < int'(sm_h.len)) begin
              burst.ch[n] = sm_h.text[8*(int'(sm_h.len)-1-i) +: 7];
              n = n + 3'd1;
            end
          end
          burst.ch[n] = dvow;
          n = n + 3'd1;
          s.output_started = 1'b1;
          consumed = 1'b1;
        end else if (kts_is_small(x)) begin
          s.error_seen = 1'b1;
        end else begin
          for (int i = 0; i < 3; i++) begin
            if (i < int'(sp_h.len)) begin
              burst.ch[n] = sp_h.text[8*(int'(sp_h.len)-1-i) +: 7];
              n = n + 3'd1;
            end
          end
          if (sp_h.len != 2'd0) s.output_started = 1'b1;
          if (st.held_kana == OFF_N && (kts_is_vowel(c0) || c0 == "y")) begin
            burst.ch[n] = 7'("'");
            n = n + 3'd1;
          end
        end
      end else if (s.double_pending) begin
        s.double_pending = 1'b0;
        if (kts_is_small(x) || c0 == 8'h0 || kts_is_vowel(c0)) begin
          s.error_seen = 1'b1;
        end else begin
          burst.ch[n] = (c0 == "c") ? 7'("t") : c0[6:0];
          n = n + 3'd1;
          s.output_started = 1'b1;
        end
      end
      if (!s.error_seen && !consumed) begin
        if (code_point == CP_LONG_MARK) begin
          if (!s.output_started) begin
            s.error_seen = 1'b1;
          end else begin
            burst.ch[n] = 7'("-");
            n = n + 3'd1;
          end
        end else if (code_point == CP_SMALL_TSU) begin
          s.double_pending = 1'b1;
        end else if (sp_x.len != 2'd0) begin
          s.held_kana = x;
          s.held_valid = 1'b1;
        end else begin
          s.error_seen = 1'b1;
        end
      end
    end
    st_nxt = s;
    burst.done = 1'b0;
    burst.inv = 1'b0;
    // end of string: flush held kana (always the kana of this item), close
    if (string_last) begin
      if (!s.error_seen) begin
        if (s.held_valid) begin
          for (int i = 0; i < 3; i++) begin
            if (i < int'(sp_x.len)) begin
              burst.ch[n] = sp_x.text[8*(int'(sp_x.len)-1-i) +: 7];
              n = n + 3'd1;
            end
          end
        end
        if (s.double_pending) s.error_seen = 1'b1;
      end
      burst.done = 1'b1;
      burst.inv = s.error_seen;
      st_nxt = '0;
    end
    burst.n = n;
  end

endmodule

### src/kana_to_romaji_stream_unit.sv
// top level of the kana to romaji stream unit: input handshake, state and
// result buffer; uses kts_pkg and kts_xlate

// Takes one hiragana code point per transfer and delivers romaji one ASCII
// character per output transfer, closing each string with an end result that
// carries the valid/invalid verdict. An input item is translated in the cycle
// it is accepted and its results (up to six chars plus the end result) are
// loaded into a burst buffer that drains one entry per cycle while out_tready
// is high; the next item is accepted in the cycle the last entry of the
// previous burst is taken, or at once when the buffer is empty, so input is
// held off while a burst drains. No clearing pass after reset.
module kana_to_romaji_stream_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // code_point[15:0]
  input  logic        in_tlast,   // string_last
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // ascii_char[6:0], zero pad
  output logic [2:0]  out_tuser,  // char_valid, string_done, string_invalid
  output logic        out_tlast   // run_last
);
  import kts_pkg::*;

  kts_state_t st_r, st_nxt;
  kts_burst_t burst;
  logic [MAX_CHARS-1:0][6:0] ch_r;
  logic [2:0] nch_r;
  logic       done_r, inv_r;
  logic [3:0] tot_r, pos_r;
  logic       in_go, out_go, last_ent, is_end;

  kts_xlate u_xlate (
    .code_point (in_tdata),
    .string_last(in_tlast),
    .st         (st_r),
    .st_nxt     (st_nxt),
    .burst      (burst)
  );

  // handshake and current entry
  assign out_tvalid = pos_r < tot_r;
  assign last_ent   = (pos_r + 4'd1) == tot_r;
  assign in_tready  = !out_tvalid || (out_tready && last_ent);
  assign in_go      = in_tvalid && in_tready;
  assign out_go     = out_tvalid && out_tready;
  assign is_end     = done_r && pos_r == {1'b0, nch_r};

  assign out_tdata = is_end ? 8'h0 : {1'b0, ch_r[pos_r[2:0]]};
  assign out_tuser = {is_end && inv_r, is_end, !is_end};
  assign out_tlast = last_ent;

  // state and burst buffer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= '0;
      tot_r <= 4'd0;
      pos_r <= 4'd0;
    end else if (in_go) begin
      st_r  <= st_nxt;
      tot_r <= {1'b0, burst.n} + {3'b0, burst.done};
      pos_r <= 4'd0;
    end else if (out_go) begin
      pos_r <= pos_r + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (in_go) begin
      ch_r   <= burst.ch;
      nch_r  <= burst.n;
      done_r <= burst.done;
      inv_r  <= burst.inv;
    end
  end

  // checks
  a_tot_bound: assert property (@(posedge clk) disable iff (!rst_n)
    tot_r <= 4'd8) else $error("burst longer than eight results");
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    in_go && out_tvalid |-> out_go && last_ent)
    else $error("item accepted while burst still pending");
  a_end_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[1] |-> out_tdata == 8'h0 && out_tlast)
    else $error("end result not last or not zero");

endmodule
